FILE: rtl/ffdha_pkg.sv
package ffdha_pkg;

   // Table and field geometry.
   localparam int DESCRIPTOR_COUNT_DEF = 64;
   localparam int HEADER_BYTES         = 16;
   localparam int TRAILER_BYTES        = 8;
   localparam int ADDR_W               = 32;
   localparam int LEN_W                = 24;
   localparam int ALIGN_W              = 13;
   localparam int NEED_W               = 26;

   // Descriptor kinds.
   localparam logic [1:0] KIND_UNUSED = 2'd0;
   localparam logic [1:0] KIND_FREE   = 2'd1;
   localparam logic [1:0] KIND_OUT    = 2'd2;

   // Operation codes.
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_COLLECT = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // Result status codes.
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NOFIT    = 2'd1;
   localparam logic [1:0] STS_NOSPARE  = 2'd2;
   localparam logic [1:0] STS_NOTALLOC = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_BASE = 1'b0;
   localparam logic CSR_SIZE = 1'b1;

   // Table write selections.
   localparam logic [2:0] WR_NONE      = 3'd0;
   localparam logic [2:0] WR_INIT      = 3'd1;
   localparam logic [2:0] WR_SPARE     = 3'd2;
   localparam logic [2:0] WR_CUR       = 3'd3;
   localparam logic [2:0] WR_FREE      = 3'd4;
   localparam logic [2:0] WR_MERGE_LEN = 3'd5;
   localparam logic [2:0] WR_MERGE_CLR = 3'd6;

   typedef struct packed {
      logic [1:0]  operation;
      logic [23:0] request_size;
      logic [12:0] alignment;
      logic [31:0] release_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] user_address;
      logic [23:0] largest_free;
      logic [23:0] total_free;
   } rsp_type;

   typedef struct packed {
      logic       req_load;
      logic       rd;
      logic       pass_clr;
      logic       first;
      logic       out_mode;
      logic       take_best;
      logic       mod_start;
      logic       need_load;
      logic [2:0] wr_sel;
      logic       status_load;
      logic [1:0] status_val;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       align_zero;
      logic       best_vld;
      logic       fits;
      logic       unused_le1;
      logic       adjacent;
      logic       rem_done;
      logic       rsp_free;
   } sts_type;

endpackage

FILE: rtl/ffdha_rem.sv
module ffdha_rem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ffdha_pkg::ADDR_W-1:0]      dividend,
   input  logic [ffdha_pkg::ALIGN_W-1:0]     divisor,
   output logic                              done,
   output logic [ffdha_pkg::ALIGN_W-1:0]     remainder
);
   import ffdha_pkg::*;

   localparam int CNT_W = $clog2(ADDR_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [ADDR_W-1:0]    num_ff;
   logic [ALIGN_W-1:0]   div_ff;
   logic [ALIGN_W-1:0]   rem_ff;
   logic [ALIGN_W:0]     trial;
   logic [ALIGN_W-1:0]   rem_in;

   // One restoring step: shift in the next dividend bit, subtract if possible.
   always_comb begin
      trial = {rem_ff, num_ff[ADDR_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = ALIGN_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[ALIGN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ADDR_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // Operand and partial remainder registers.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[ADDR_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/ffdha_dp.sv
module ffdha_dp #(
   parameter int DESCRIPTOR_COUNT = ffdha_pkg::DESCRIPTOR_COUNT_DEF,
   parameter int IDX_W            = $clog2(DESCRIPTOR_COUNT)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [31:0]          csr_write_data,
   input  ffdha_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ffdha_pkg::rsp_type   rsp_data,
   input  ffdha_pkg::cmd_type   cmd,
   input  logic [IDX_W-1:0]     idx,
   output ffdha_pkg::sts_type   sts
);
   import ffdha_pkg::*;

   localparam logic [ADDR_W-1:0] HDR      = ADDR_W'(HEADER_BYTES);
   localparam logic [NEED_W-1:0] OVERHEAD = NEED_W'(HEADER_BYTES + TRAILER_BYTES);

   // Descriptor table memories.
   logic [1:0]        kind_mem  [DESCRIPTOR_COUNT];
   logic [ADDR_W-1:0] start_mem [DESCRIPTOR_COUNT];
   logic [LEN_W-1:0]  len_mem   [DESCRIPTOR_COUNT];
   logic [ADDR_W-1:0] hand_mem  [DESCRIPTOR_COUNT];

   logic [1:0]        kind_q;
   logic [ADDR_W-1:0] start_q;
   logic [LEN_W-1:0]  len_q;
   logic [ADDR_W-1:0] hand_q;

   // Configuration and request registers.
   logic [ADDR_W-1:0] base_ff;
   logic [LEN_W-1:0]  size_ff;
   req_type           req_ff;

   // Scan accumulators.
   logic              rd_pend_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              best_vld_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [ADDR_W-1:0] best_start_ff;
   logic [LEN_W-1:0]  best_len_ff;
   logic [1:0]        unused_cnt_ff;
   logic              spare_vld_ff;
   logic [IDX_W-1:0]  spare_idx_ff;
   logic [LEN_W-1:0]  largest_ff;
   logic [LEN_W-1:0]  total_ff;

   // Current block and allocate arithmetic.
   logic [IDX_W-1:0]  cur_idx_ff;
   logic [ADDR_W-1:0] cur_start_ff;
   logic [LEN_W-1:0]  cur_len_ff;
   logic [NEED_W-1:0] need_ff;
   logic [1:0]        status_ff;
   logic [ADDR_W-1:0] uaddr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic                rem_done;
   logic [ALIGN_W-1:0]  rem;
   logic [ALIGN_W-1:0]  pad;
   logic [NEED_W-1:0]   need_in;
   logic [ADDR_W-1:0]   uaddr_calc;
   logic [LEN_W-1:0]    merge_len;
   logic                adjacent;
   logic                fits;
   logic                exact;
   logic [LEN_W:0]      total_sum;

   // Table write port.
   logic              we_kind;
   logic              we_start;
   logic              we_len;
   logic              we_hand;
   logic [IDX_W-1:0]  waddr;
   logic [1:0]        wkind;
   logic [ADDR_W-1:0] wstart;
   logic [LEN_W-1:0]  wlen;

   ffdha_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (best_start_ff + HDR),
      .divisor   (req_ff.alignment),
      .done      (rem_done),
      .remainder (rem)
   );

   // Padding, space needed and the address handed out.
   always_comb begin
      pad        = (req_ff.alignment == '0) ? '0 : req_ff.alignment - rem;
      need_in    = NEED_W'(req_ff.request_size) + OVERHEAD + NEED_W'(pad);
      uaddr_calc = cur_start_ff + HDR + ADDR_W'(pad);
      merge_len  = cur_len_ff + best_len_ff;
      adjacent   = (cur_start_ff + ADDR_W'(cur_len_ff)) == best_start_ff;
      fits       = NEED_W'(cur_len_ff) >= need_ff;
      exact      = NEED_W'(cur_len_ff) == need_ff;
      total_sum  = {1'b0, total_ff} + {1'b0, len_q};
   end

   // Write port selection.
   always_comb begin
      we_kind  = 1'b0;
      we_start = 1'b0;
      we_len   = 1'b0;
      we_hand  = 1'b0;
      waddr    = cur_idx_ff;
      wkind    = KIND_UNUSED;
      wstart   = '0;
      wlen     = '0;
      case (cmd.wr_sel)
         WR_INIT: begin
            we_kind  = 1'b1;
            we_start = 1'b1;
            we_len   = 1'b1;
            waddr    = idx;
            if (idx == '0) begin
               wkind  = KIND_FREE;
               wstart = base_ff;
               wlen   = size_ff;
            end
         end
         WR_SPARE: begin
            we_kind  = 1'b1;
            we_start = 1'b1;
            we_len   = 1'b1;
            we_hand  = 1'b1;
            waddr    = spare_idx_ff;
            wkind    = KIND_OUT;
            wstart   = cur_start_ff;
            wlen     = need_ff[LEN_W-1:0];
         end
         WR_CUR: begin
            we_kind  = 1'b1;
            we_start = 1'b1;
            we_len   = 1'b1;
            if (!exact) begin
               wkind  = KIND_FREE;
               wstart = cur_start_ff + ADDR_W'(need_ff);
               wlen   = cur_len_ff - need_ff[LEN_W-1:0];
            end
         end
         WR_FREE: begin
            we_kind = 1'b1;
            waddr   = best_idx_ff;
            wkind   = KIND_FREE;
         end
         WR_MERGE_LEN: begin
            we_len = 1'b1;
            wlen   = merge_len;
         end
         WR_MERGE_CLR: begin
            we_kind  = 1'b1;
            we_start = 1'b1;
            we_len   = 1'b1;
            waddr    = best_idx_ff;
         end
         default: begin
         end
      endcase
   end

   // Memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we_kind) begin
         kind_mem[waddr] <= wkind;
      end
      kind_q <= kind_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (we_start) begin
         start_mem[waddr] <= wstart;
      end
      start_q <= start_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (we_len) begin
         len_mem[waddr] <= wlen;
      end
      len_q <= len_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (we_hand) begin
         hand_mem[waddr] <= uaddr_calc;
      end
      hand_q <= hand_mem[idx];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= LEN_W'(65536);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE: base_ff <= csr_write_data;
            CSR_SIZE: size_ff <= csr_write_data[LEN_W-1:0];
            default:  base_ff <= base_ff;
         endcase
      end
   end

   // Scan evaluation, one table entry per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff    <= 1'b0;
         best_vld_ff   <= 1'b0;
         spare_vld_ff  <= 1'b0;
         unused_cnt_ff <= '0;
      end else begin
         rd_pend_ff <= cmd.rd;
         if (cmd.pass_clr) begin
            best_vld_ff   <= 1'b0;
            spare_vld_ff  <= 1'b0;
            unused_cnt_ff <= '0;
            largest_ff    <= '0;
            total_ff      <= '0;
         end else if (rd_pend_ff) begin
            if (kind_q == KIND_UNUSED) begin
               if (unused_cnt_ff != 2'd2) begin
                  unused_cnt_ff <= unused_cnt_ff + 1'b1;
               end
               if (!spare_vld_ff) begin
                  spare_vld_ff <= 1'b1;
                  spare_idx_ff <= rd_idx_ff;
               end
            end
            if (cmd.out_mode) begin
               if (kind_q == KIND_OUT && hand_q == req_ff.release_address
                   && !best_vld_ff) begin
                  best_vld_ff <= 1'b1;
                  best_idx_ff <= rd_idx_ff;
               end
            end else if (kind_q == KIND_FREE && (cmd.first || start_q > cur_start_ff)
                         && (!best_vld_ff || start_q < best_start_ff)) begin
               best_vld_ff   <= 1'b1;
               best_idx_ff   <= rd_idx_ff;
               best_start_ff <= start_q;
               best_len_ff   <= len_q;
            end
            if (kind_q == KIND_FREE) begin
               if (len_q > largest_ff) begin
                  largest_ff <= len_q;
               end
               total_ff <= total_sum[LEN_W] ? '1 : total_sum[LEN_W-1:0];
            end
         end
      end
      rd_idx_ff <= idx;
   end

   // Request, current block and result registers.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff    <= req_data;
         status_ff <= STS_OK;
         uaddr_ff  <= '0;
      end
      if (cmd.status_load) begin
         status_ff <= cmd.status_val;
      end
      if (cmd.take_best) begin
         cur_idx_ff   <= best_idx_ff;
         cur_start_ff <= best_start_ff;
         cur_len_ff   <= best_len_ff;
      end else if (cmd.wr_sel == WR_MERGE_LEN) begin
         cur_len_ff <= merge_len;
      end
      if (cmd.need_load) begin
         need_ff <= need_in;
      end
      if (cmd.wr_sel == WR_SPARE) begin
         uaddr_ff <= uaddr_calc;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.user_address <= uaddr_ff;
         rsp_ff.largest_free <= largest_ff;
         rsp_ff.total_free   <= total_ff;
      end
   end

   // Result beat valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts.op         = req_ff.operation;
      sts.align_zero = req_ff.alignment == '0;
      sts.best_vld   = best_vld_ff;
      sts.fits       = fits;
      sts.unused_le1 = unused_cnt_ff != 2'd2;
      sts.adjacent   = adjacent;
      sts.rem_done   = rem_done;
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

FILE: rtl/ffdha_ctrl.sv
module ffdha_ctrl #(
   parameter int DESCRIPTOR_COUNT = ffdha_pkg::DESCRIPTOR_COUNT_DEF,
   parameter int IDX_W            = $clog2(DESCRIPTOR_COUNT)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_stall,
   input  logic                 csr_write_enable,
   input  ffdha_pkg::sts_type   sts,
   output ffdha_pkg::cmd_type   cmd,
   output logic [IDX_W-1:0]     idx
);
   import ffdha_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DESCRIPTOR_COUNT - 1);

   localparam logic [3:0] S_INIT      = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_SCAN      = 4'd2;
   localparam logic [3:0] S_TAIL      = 4'd3;
   localparam logic [3:0] S_DECIDE    = 4'd4;
   localparam logic [3:0] S_MOD_WAIT  = 4'd5;
   localparam logic [3:0] S_NEED      = 4'd6;
   localparam logic [3:0] S_FIT       = 4'd7;
   localparam logic [3:0] S_WR_SPARE  = 4'd8;
   localparam logic [3:0] S_WR_CUR    = 4'd9;
   localparam logic [3:0] S_FREE_WR   = 4'd10;
   localparam logic [3:0] S_MERGE_A   = 4'd11;
   localparam logic [3:0] S_MERGE_B   = 4'd12;
   localparam logic [3:0] S_RESP      = 4'd13;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             first_ff, first_in;
   logic             stat_ff, stat_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      stat_in      = stat_ff;
      cmd          = '0;
      cmd.wr_sel   = WR_NONE;
      cmd.first    = first_ff;
      cmd.out_mode = (sts.op == OP_FREE) && !stat_ff;
      unique case (state_ff)
         // Clearing pass over the descriptor table.
         S_INIT: begin
            cmd.wr_sel = WR_INIT;
            if (csr_write_enable) begin
               idx_in = '0;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (csr_write_enable) begin
               state_in = S_INIT;
               idx_in   = '0;
            end else if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_SCAN;
               idx_in       = '0;
               first_in     = 1'b1;
               stat_in      = (req_op == OP_NONE);
            end
         end
         // Table walk: one read issued per cycle.
         S_SCAN: begin
            cmd.rd       = 1'b1;
            cmd.pass_clr = (idx_ff == '0);
            if (idx_ff == LAST_IDX) begin
               state_in = S_TAIL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TAIL: begin
            state_in = stat_ff ? S_RESP : S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_SCAN;
            idx_in   = '0;
            case (sts.op)
               OP_ALLOC: begin
                  if (!sts.best_vld) begin
                     cmd.status_load = 1'b1;
                     cmd.status_val  = STS_NOFIT;
                     stat_in         = 1'b1;
                  end else begin
                     cmd.take_best = 1'b1;
                     if (sts.align_zero) begin
                        state_in = S_NEED;
                     end else begin
                        cmd.mod_start = 1'b1;
                        state_in      = S_MOD_WAIT;
                     end
                  end
               end
               OP_FREE: begin
                  if (sts.best_vld) begin
                     state_in = S_FREE_WR;
                  end else begin
                     cmd.status_load = 1'b1;
                     cmd.status_val  = STS_NOTALLOC;
                     stat_in         = 1'b1;
                  end
               end
               OP_COLLECT: begin
                  if (!sts.best_vld) begin
                     stat_in = 1'b1;
                  end else if (first_ff) begin
                     cmd.take_best = 1'b1;
                     first_in      = 1'b0;
                  end else if (sts.adjacent) begin
                     state_in = S_MERGE_A;
                  end else begin
                     cmd.take_best = 1'b1;
                  end
               end
               default: begin
                  stat_in = 1'b1;
               end
            endcase
         end
         S_MOD_WAIT: begin
            if (sts.rem_done) begin
               state_in = S_NEED;
            end
         end
         S_NEED: begin
            cmd.need_load = 1'b1;
            state_in      = S_FIT;
         end
         S_FIT: begin
            state_in = S_SCAN;
            idx_in   = '0;
            if (!sts.fits) begin
               first_in = 1'b0;
            end else if (sts.unused_le1) begin
               cmd.status_load = 1'b1;
               cmd.status_val  = STS_NOSPARE;
               stat_in         = 1'b1;
            end else begin
               state_in = S_WR_SPARE;
            end
         end
         S_WR_SPARE: begin
            cmd.wr_sel = WR_SPARE;
            state_in   = S_WR_CUR;
         end
         S_WR_CUR: begin
            cmd.wr_sel = WR_CUR;
            state_in   = S_SCAN;
            idx_in     = '0;
            stat_in    = 1'b1;
         end
         S_FREE_WR: begin
            cmd.wr_sel = WR_FREE;
            state_in   = S_SCAN;
            idx_in     = '0;
            stat_in    = 1'b1;
         end
         S_MERGE_A: begin
            cmd.wr_sel = WR_MERGE_LEN;
            state_in   = S_MERGE_B;
         end
         S_MERGE_B: begin
            cmd.wr_sel = WR_MERGE_CLR;
            state_in   = S_SCAN;
            idx_in     = '0;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff   <= '0;
         first_ff <= 1'b1;
         stat_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         first_ff <= first_in;
         stat_ff  <= stat_in;
      end
   end

   assign idx       = idx_ff;
   assign req_stall = (state_ff != S_IDLE) || csr_write_enable;

endmodule

FILE: rtl/first_fit_descriptor_heap_allocator_top.sv
// First-fit heap allocator over a table of DESCRIPTOR_COUNT block descriptors.
// Requests arrive on req_valid/req_stall/req_data (allocate, free, collect);
// each request yields one result beat on rsp_valid/rsp_stall/rsp_data with a
// status, the user address of an allocation, and the largest and total free
// byte counts after the request.
// The descriptor table lives in single-port-read memories, so all work is a
// walk over the table of N = DESCRIPTOR_COUNT entries, one entry a cycle.
// Free takes two walks and no-op one walk; allocate takes one walk per free
// block it tries in address order, plus a remainder iteration per try when
// alignment is set, plus a final statistics walk.
// Collect takes one walk per free block visited or merged, up to about N walks.
// One request is in flight at a time; req_stall is low only when idle. A
// finished result waits in the output register, so the next request may be
// taken while the receiver stalls the previous result beat.
// Reset, and a csr_ write while idle or clearing, starts a clearing pass that
// rebuilds the table as one free block over the region; requests are stalled
// meanwhile. Configuration must be written only while idle (not enforced).
module first_fit_descriptor_heap_allocator_top #(
   parameter int DESCRIPTOR_COUNT = ffdha_pkg::DESCRIPTOR_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ffdha_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ffdha_pkg::rsp_type   rsp_data,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [31:0]          csr_write_data
);
   import ffdha_pkg::*;

   localparam int IDX_W = $clog2(DESCRIPTOR_COUNT);

   cmd_type          cmd;
   sts_type          sts;
   logic [IDX_W-1:0] idx;

   ffdha_ctrl #(
      .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT),
      .IDX_W            (IDX_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_op           (req_data.operation),
      .req_stall        (req_stall),
      .csr_write_enable (csr_write_enable),
      .sts              (sts),
      .cmd              (cmd),
      .idx              (idx)
   );

   ffdha_dp #(
      .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT),
      .IDX_W            (IDX_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .idx              (idx),
      .sts              (sts)
   );

   // One request at a time: an accepted beat is followed by a busy cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a previous one is in flight");

   // Failed requests never hand out an address.
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STS_OK) |-> (rsp_data.user_address == '0))
      else $error("failed request reports a user address");

   // The largest free block never exceeds the total free bytes.
   a_largest_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.largest_free <= rsp_data.total_free))
      else $error("largest free block exceeds total free bytes");

endmodule
